// ===== design/fcbs_pkg.sv =====
package fcbs_pkg;

   // field widths
   localparam int ByteW   = 8;
   localparam int CsrIdxW = 2;

   // register reset values and limits
   localparam logic [ByteW-1:0] FrameLenReset = 8'd27;
   localparam logic [ByteW-1:0] MinFrameLen   = 8'd4;

   // characters that get stuffed, and their escape codes
   localparam logic [ByteW-1:0] EscChar   = 8'h5C;  // backslash
   localparam logic [ByteW-1:0] StartChar = 8'h24;  // '$'
   localparam logic [ByteW-1:0] CaretChar = 8'h5E;  // '^'
   localparam logic [ByteW-1:0] CodeEsc   = 8'h30;  // '0'
   localparam logic [ByteW-1:0] CodeStart = 8'h31;  // '1'
   localparam logic [ByteW-1:0] CodeCaret = 8'h32;  // '2'

   typedef logic [ByteW-1:0] byte_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_LENGTH = 2'd0,
      CSR_ESCAPE_CARET = 2'd1
   } csr_index_type;

   typedef struct packed {
      byte_type frame_length;
      logic     escape_caret;
   } cfg_type;

   // encoded item: tail byte, whether an escape byte goes first, frame end
   typedef struct packed {
      byte_type tail_byte;
      logic     escaped;
      logic     ends;
   } enc_type;

endpackage

// ===== design/fcbs_if.sv =====
interface fcbs_req_if;
   import fcbs_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcbs_rsp_if;
   import fcbs_pkg::*;
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     run_last;
   logic     frame_done;
   modport source (output valid, output out_byte, output run_last, output frame_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_done,
                   output ready);
endinterface

interface fcbs_csr_if;
   import fcbs_pkg::*;
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   byte_type           data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fcbs_csr_regs.sv =====
module fcbs_csr_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [fcbs_pkg::CsrIdxW-1:0] wr_index,
   input  fcbs_pkg::byte_type          wr_data,
   output fcbs_pkg::cfg_type           cfg
);
   import fcbs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_FRAME_LENGTH: cfg_in.frame_length = wr_data;
            CSR_ESCAPE_CARET: cfg_in.escape_caret = wr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length <= FrameLenReset;
         cfg_ff.escape_caret <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/fcbs_encoder.sv =====
module fcbs_encoder (
   input  logic               clock,
   input  logic               reset,
   input  fcbs_pkg::cfg_type  cfg,
   input  logic               accept,
   input  fcbs_pkg::byte_type data_byte,
   output fcbs_pkg::enc_type  enc
);
   import fcbs_pkg::*;

   byte_type pos_ff, pos_in;
   byte_type sum_ff, sum_in;
   byte_type len;
   byte_type tx_byte;
   byte_type code;
   logic     at_start;
   logic     ends;
   logic     at_sum;
   logic     escaped;

   // frame position decode; short lengths are taken as the minimum
   always_comb begin
      len      = (cfg.frame_length < MinFrameLen) ? MinFrameLen : cfg.frame_length;
      at_start = (pos_ff == '0);
      ends     = !at_start && (pos_ff >= len - 8'd1);
      at_sum   = !at_start && !ends && (pos_ff == len - 8'd2);
      tx_byte  = at_sum ? sum_ff - 8'd1 : data_byte;
   end

   // stuffing: start marker is never escaped
   always_comb begin
      escaped = 1'b0;
      code    = tx_byte;
      if (!at_start) begin
         if (tx_byte == EscChar) begin
            escaped = 1'b1;
            code    = CodeEsc;
         end else if (tx_byte == StartChar) begin
            escaped = 1'b1;
            code    = CodeStart;
         end else if (tx_byte == CaretChar && cfg.escape_caret) begin
            escaped = 1'b1;
            code    = CodeCaret;
         end
      end
      enc.tail_byte = code;
      enc.escaped   = escaped;
      enc.ends      = ends;
   end

   // position and running sum
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (at_start || ends) begin
            sum_in = '0;
         end else if (!at_sum) begin
            sum_in = sum_ff + data_byte;
         end
         pos_in = ends ? '0 : pos_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== design/fcbs_out_buf.sv =====
module fcbs_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  fcbs_pkg::enc_type  enc,
   output logic               can_load,
   output logic               out_valid,
   input  logic               out_ready,
   output fcbs_pkg::byte_type out_byte,
   output logic               run_last,
   output logic               frame_done
);
   import fcbs_pkg::*;

   // beats still to send: 2 = escape then tail, 1 = tail only
   logic [1:0] beats_ff, beats_in;
   byte_type   tail_ff, tail_in;
   logic       ends_ff, ends_in;
   logic       pop;

   assign pop      = out_valid && out_ready;
   assign can_load = (beats_ff == 2'd0) || (beats_ff == 2'd1 && out_ready);

   always_comb begin
      beats_in = beats_ff;
      tail_in  = tail_ff;
      ends_in  = ends_ff;
      if (pop) begin
         beats_in = beats_ff - 2'd1;
      end
      if (load) begin
         beats_in = enc.escaped ? 2'd2 : 2'd1;
         tail_in  = enc.tail_byte;
         ends_in  = enc.ends;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= 2'd0;
      end else begin
         beats_ff <= beats_in;
      end
      tail_ff <= tail_in;
      ends_ff <= ends_in;
   end

   // escape beat first, then the tail beat
   always_comb begin
      out_valid  = (beats_ff != 2'd0);
      out_byte   = (beats_ff == 2'd2) ? EscChar : tail_ff;
      run_last   = (beats_ff != 2'd2);
      frame_done = (beats_ff != 2'd2) && ends_ff;
   end

endmodule

// ===== design/frame_checksum_byte_stuffer_top.sv =====
// Byte-stuffing framer with an additive checksum. Frame bytes enter one per
// beat on req_ch; byte 0 passes unchanged, bytes 1 to length-3 are summed,
// the byte at length-2 is replaced by (sum - 1) mod 256 and the byte after it
// closes the frame. From position 1 on, backslash, '$' and (when
// escape_caret is set) '^' go out as a backslash and a code byte. An
// escaped byte goes out as two beats and any other as one; the single
// output register sends one beat per cycle while rsp_ch is ready, and a
// new byte is taken in the cycle the previous one's last beat leaves.
// Write csr_ch only while the block is idle.
module frame_checksum_byte_stuffer_top (
   input  logic       clock,
   input  logic       reset,
   fcbs_req_if.sink   req_ch,
   fcbs_rsp_if.source rsp_ch,
   fcbs_csr_if.sink   csr_ch
);
   import fcbs_pkg::*;

   cfg_type cfg;
   enc_type enc;
   logic    can_load;
   logic    req_accept;

   // configuration registers, always ready
   assign csr_ch.ready = 1'b1;

   fcbs_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // input beat handshake
   assign req_ch.ready = can_load;
   assign req_accept   = req_ch.valid && can_load;

   fcbs_encoder u_enc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (req_accept),
      .data_byte (req_ch.data_byte),
      .enc       (enc)
   );

   fcbs_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .enc        (enc),
      .can_load   (can_load),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_byte   (rsp_ch.out_byte),
      .run_last   (rsp_ch.run_last),
      .frame_done (rsp_ch.frame_done)
   );

endmodule

// ===== design/fcbs_checker.sv =====
module fcbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input fcbs_pkg::byte_type rsp_out_byte,
   input logic               rsp_run_last,
   input logic               rsp_frame_done
);
   import fcbs_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_frame_done))
      else $error("result beat changed while stalled");

   // the first beat of a pair is always the escape character, never a frame end
   a_esc_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_out_byte == EscChar && !rsp_frame_done)
      else $error("non-last beat is not a plain escape");

   // the code byte follows its escape at once
   a_pair_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid && rsp_run_last)
      else $error("escape beat not followed by its code byte");

   // frame end only on the last beat of an item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_last)
      else $error("frame end on a non-last beat");

   // nothing pending after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind frame_checksum_byte_stuffer_top fcbs_checker u_fcbs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_byte   (rsp_ch.out_byte),
   .rsp_run_last   (rsp_ch.run_last),
   .rsp_frame_done (rsp_ch.frame_done)
);

// ===== dv/tb_frame_checksum_byte_stuffer_top.sv =====
`timescale 1ns / 1ps

module tb_frame_checksum_byte_stuffer_top;
   import fcbs_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomBytes = 700;
   localparam int QuietFrom   = 600;
   localparam int HoldCycles  = 48;
   localparam int DrainCycles = 8;

   // indexes past the register map, which the block must ignore
   localparam logic [CsrIdxW-1:0] CsrSpareA = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrSpareB = 2'd3;

   typedef struct packed {
      byte_type out_byte;
      logic     run_last;
      logic     frame_done;
   } line_beat_type;

   localparam line_beat_type NoBeat = '0;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   // n_typed: 0 = expectation from the predictor, 1 or 2 = beats typed in the row
   typedef struct packed {
      row_kind_type       kind;
      logic [CsrIdxW-1:0] idx;
      byte_type           value;
      logic [1:0]         n_typed;
      line_beat_type      head;
      line_beat_type      tail;
   } step_row_type;

   logic clock;
   logic reset;

   fcbs_req_if req_ch ();
   fcbs_rsp_if rsp_ch ();
   fcbs_csr_if csr_ch ();

   frame_checksum_byte_stuffer_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // directed frames: short and long lengths, every escape, checksum edge values
   step_row_type directed_steps [31] = '{
      '{ROW_CSR,  CSR_FRAME_LENGTH, 8'd4,  2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h24, 2'd1, '{StartChar, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h00, 2'd1, '{8'h00, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h9A, 2'd1, '{8'hFF, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h5C, 2'd2, '{EscChar, 1'b0, 1'b0}, '{CodeEsc, 1'b1, 1'b1}},
      '{ROW_BYTE, '0, 8'h5C, 2'd1, '{EscChar, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h5D, 2'd1, '{8'h5D, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h00, 2'd2, '{EscChar, 1'b0, 1'b0}, '{CodeEsc, 1'b1, 1'b0}},
      '{ROW_BYTE, '0, 8'h5E, 2'd1, '{CaretChar, 1'b1, 1'b1}, NoBeat},
      '{ROW_CSR,  CSR_ESCAPE_CARET, 8'hFF, 2'd0, NoBeat, NoBeat},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 8'd0,  2'd0, NoBeat, NoBeat},
      '{ROW_CSR,  CsrSpareA,        8'h07, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'hFF, 2'd1, '{8'hFF, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h5E, 2'd2, '{EscChar, 1'b0, 1'b0}, '{CodeCaret, 1'b1, 1'b0}},
      '{ROW_BYTE, '0, 8'hAA, 2'd1, '{8'h5D, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'h24, 2'd2, '{EscChar, 1'b0, 1'b0}, '{CodeStart, 1'b1, 1'b1}},
      '{ROW_CSR,  CSR_ESCAPE_CARET, 8'hFE, 2'd0, NoBeat, NoBeat},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 8'd255, 2'd0, NoBeat, NoBeat},
      '{ROW_CSR,  CsrSpareB,        8'h03, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h00, 2'd1, '{8'h00, 1'b1, 1'b0}, NoBeat},
      '{ROW_BYTE, '0, 8'hFF, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h5E, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h24, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h80, 2'd0, NoBeat, NoBeat},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 8'd5,  2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h11, 2'd1, '{8'h11, 1'b1, 1'b1}, NoBeat},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 8'd3,  2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h01, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h25, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'h00, 2'd0, NoBeat, NoBeat},
      '{ROW_BYTE, '0, 8'hFF, 2'd0, NoBeat, NoBeat}
   };

   // framer state as the testbench sees it
   byte_type frame_len_cfg;
   logic     caret_cfg;
   byte_type pos_cnt;
   byte_type chk_sum;

   line_beat_type line_beats_due [$];

   int  error_count   = 0;
   int  bytes_sent    = 0;
   int  beats_seen    = 0;
   int  frames_seen   = 0;
   int  escape_pairs  = 0;
   int  cycle_count   = 0;
   int  req_gap_pct   = 10;
   int  rsp_stall_pct = 10;
   int  rsp_idle_left = 0;
   int  hold_left     = 0;
   int  hold_asked    = 0;
   int  hold_served   = 0;
   bit  quiet_tail    = 1'b0;

   // clock, 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                  line_beats_due.size());
         $display("frame_checksum_byte_stuffer_top regression: fail");
         $finish;
      end
   end

   // encode one raw byte: advance position and sum, return one or two line beats
   function automatic void encode_byte(input byte_type raw, output line_beat_type head,
                                       output line_beat_type tail, output logic pair);
      byte_type eff_len;
      byte_type b;
      byte_type code;
      logic     ends;
      eff_len = (frame_len_cfg < MinFrameLen) ? MinFrameLen : frame_len_cfg;
      b       = raw;
      code    = '0;
      pair    = 1'b0;
      tail    = NoBeat;
      // start marker goes out untouched and restarts the sum
      if (pos_cnt == 8'd0) begin
         chk_sum = '0;
         pos_cnt = 8'd1;
         head    = '{b, 1'b1, 1'b0};
         return;
      end
      // anything at or past the trailer slot closes the frame
      ends = (pos_cnt >= eff_len - 8'd1);
      if (!ends) begin
         if (pos_cnt == eff_len - 8'd2) begin
            b = chk_sum - 8'd1;
         end else begin
            chk_sum = chk_sum + b;
         end
      end
      if (b == EscChar) begin
         pair = 1'b1;
         code = CodeEsc;
      end else if (b == StartChar) begin
         pair = 1'b1;
         code = CodeStart;
      end else if (b == CaretChar && caret_cfg) begin
         pair = 1'b1;
         code = CodeCaret;
      end
      if (ends) begin
         pos_cnt = '0;
         chk_sum = '0;
      end else begin
         pos_cnt = pos_cnt + 8'd1;
      end
      if (pair) begin
         head = '{EscChar, 1'b0, 1'b0};
         tail = '{code, 1'b1, ends};
      end else begin
         head = '{b, 1'b1, ends};
      end
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // line side checker
   always @(posedge clock) begin : line_check
      line_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         beats_seen++;
         if (rsp_ch.frame_done) frames_seen++;
         if (line_beats_due.size() == 0) begin
            report_mismatch($sformatf("beat %02h with nothing due", rsp_ch.out_byte));
         end else begin
            want = line_beats_due.pop_front();
            if (rsp_ch.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_ch.out_byte, want.out_byte));
            if (rsp_ch.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                         rsp_ch.run_last, want.run_last, want.out_byte));
            if (rsp_ch.frame_done !== want.frame_done)
               report_mismatch($sformatf("frame_done %b, want %b (byte %02h)",
                                         rsp_ch.frame_done, want.frame_done, want.out_byte));
         end
      end
   end

   // line side ready: random stall bursts, plus a long hold when asked for
   always @(negedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_idle_left > 0) begin
         rsp_idle_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(1, 100) <= rsp_stall_pct) begin
         rsp_idle_left = $urandom_range(0, 5);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // offer one frame byte, wait for its beat, then book the expected line beats
   task automatic send_byte(input byte_type raw, input logic [1:0] n_typed,
                            input line_beat_type typed_head,
                            input line_beat_type typed_tail);
      line_beat_type head;
      line_beat_type tail;
      logic          pair;
      int            gap;
      gap = 0;
      if (!quiet_tail && $urandom_range(1, 100) <= req_gap_pct) gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= raw;
      do @(posedge clock); while (!req_ch.ready);
      encode_byte(raw, head, tail, pair);
      if (n_typed != 2'd0) begin
         head = typed_head;
         tail = typed_tail;
         pair = (n_typed == 2'd2);
      end
      line_beats_due.push_back(head);
      if (pair) begin
         line_beats_due.push_back(tail);
         escape_pairs++;
      end
      bytes_sent++;
   endtask

   // stop offering and wait until every booked beat has left
   task automatic settle_idle();
      if (req_ch.valid) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      while (line_beats_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input byte_type value);
      settle_idle();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_FRAME_LENGTH: frame_len_cfg = value;
         CSR_ESCAPE_CARET: caret_cfg = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int       phase;
      int       count;
      int       n;
      byte_type raw;
      byte_type len_pick;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      frame_len_cfg    = FrameLenReset;
      caret_cfg        = 1'b0;
      pos_cnt          = '0;
      chk_sum          = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_CSR) begin
            write_csr(directed_steps[i].idx, directed_steps[i].value);
         end else begin
            send_byte(directed_steps[i].value, directed_steps[i].n_typed,
                      directed_steps[i].head, directed_steps[i].tail);
         end
      end

      // random phases, each with its own length, caret mode and idling mix
      phase = 0;
      count = 0;
      while (count < RandomBytes) begin
         case ($urandom_range(0, 2))
            0: req_gap_pct = 0;
            1: req_gap_pct = 10;
            default: req_gap_pct = 30;
         endcase
         case ($urandom_range(0, 2))
            0: rsp_stall_pct = 0;
            1: rsp_stall_pct = 10;
            default: rsp_stall_pct = 30;
         endcase
         case ($urandom_range(0, 9))
            0: len_pick = byte_type'($urandom_range(0, 3));
            1: len_pick = MinFrameLen;
            default: len_pick = byte_type'($urandom_range(5, 24));
         endcase
         // one phase runs a full-length frame through to its trailer
         if (phase == 2) len_pick = 8'd255;
         write_csr(CSR_FRAME_LENGTH, len_pick);
         write_csr(CSR_ESCAPE_CARET, byte_type'($urandom));
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CsrSpareA : CsrSpareB, byte_type'($urandom));
         n = (phase == 2) ? 255 - int'(pos_cnt) : $urandom_range(20, 60);
         // line side holds off long enough to back the block up
         if (phase == 4) hold_asked++;
         for (int k = 0; k < n; k++) begin
            if (phase == 6 && k == n / 2) settle_idle();
            case ($urandom_range(0, 7))
               0: raw = EscChar;
               1: raw = StartChar;
               2: raw = CaretChar;
               default: raw = byte_type'($urandom);
            endcase
            send_byte(raw, 2'd0, NoBeat, NoBeat);
            count++;
            if (count >= QuietFrom) quiet_tail = 1'b1;
         end
         phase++;
      end

      settle_idle();
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d frame bytes over %0d phases: %0d line beats, %0d escape pairs,",
               bytes_sent, phase, beats_seen, escape_pairs);
      $display("%0d frames closed, lengths 0 to 255, caret on and off, long line-side hold",
               frames_seen);
      if (error_count == 0) begin
         $display("frame_checksum_byte_stuffer_top regression: pass");
      end else begin
         $display("frame_checksum_byte_stuffer_top regression: fail");
      end
      $finish;
   end

endmodule
